// File: rtl/cwgr_pkg.sv
// ----------------------------------------------------------------------------
// cwgr_pkg
// Shared constants, lane control struct and helper functions for the
// chunked weight gradient reducer.
// ----------------------------------------------------------------------------
package cwgr_pkg;

  // number of parallel lanes, fixed by the port list
  localparam int unsigned LANES = 8;
  // default samples per chunk
  localparam int unsigned CHUNK_DEF = 128;
  // cycles from operand load until the fma result is valid
  localparam int unsigned FMA_LAT = 4;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [31:0] ONE32  = 32'h3F80_0000;
  localparam logic [31:0] INF32  = 32'h7F80_0000;

  // per-lane control from the sequencer
  typedef struct packed {
    logic load_mac;    // load act * residual + partial
    logic load_flush;  // load new partial (fma result) * 1.0 + total, clear partial
    logic wr_partial;  // store fma result into partial
    logic wr_total;    // store fma result into total
    logic clear;       // clear all lane state after emit
  } lane_ctrl_t;

  // index of the highest set bit, zero for a zero word
  function automatic logic [5:0] top_bit64(input logic [63:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(i);
    end
    return n;
  endfunction

  // fp32 to bf16, round half to even on the bits
  function automatic logic [15:0] to_bf16(input logic [31:0] bits);
    logic [31:0] s;
    s = bits + 32'h0000_7FFF + {31'b0, bits[16]};
    return s[31:16];
  endfunction

endpackage

// File: rtl/cwgr_fma.sv
// ----------------------------------------------------------------------------
// cwgr_fma
// Pipelined fp32 fused multiply-add a * b + c, one rounding to nearest
// even, subnormals exact. Four register stages, free running.
// ----------------------------------------------------------------------------
module cwgr_fma (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] res_o
);

  // stage 1: unpack, special cases, mantissa product
  logic        sa, sb, sc, sp;
  logic        ainf, binf, cinf, anan, bnan, cnan, azero, bzero, czero;
  logic [23:0] ma, mb, mc;
  logic signed [11:0] ea, eb, ec;
  logic        spec;
  logic [31:0] sval;

  always_comb begin
    sa = a_i[31];
    sb = b_i[31];
    sc = c_i[31];
    sp = sa ^ sb;
    ainf = a_i[30:23] == 8'hFF;
    binf = b_i[30:23] == 8'hFF;
    cinf = c_i[30:23] == 8'hFF;
    anan = ainf && (a_i[22:0] != '0);
    bnan = binf && (b_i[22:0] != '0);
    cnan = cinf && (c_i[22:0] != '0);
    azero = a_i[30:0] == '0;
    bzero = b_i[30:0] == '0;
    czero = c_i[30:0] == '0;
    ma = {a_i[30:23] != '0, a_i[22:0]};
    mb = {b_i[30:23] != '0, b_i[22:0]};
    mc = {c_i[30:23] != '0, c_i[22:0]};
    ea = (a_i[30:23] == '0) ? -12'sd149 : $signed({4'b0, a_i[30:23]}) - 12'sd150;
    eb = (b_i[30:23] == '0) ? -12'sd149 : $signed({4'b0, b_i[30:23]}) - 12'sd150;
    ec = (c_i[30:23] == '0) ? -12'sd149 : $signed({4'b0, c_i[30:23]}) - 12'sd150;
    spec = 1'b1;
    sval = cwgr_pkg::QNAN32;
    priority if (anan || bnan || cnan) begin
      sval = cwgr_pkg::QNAN32;
    end else if (ainf || binf) begin
      if (azero || bzero || (cinf && sc != sp)) sval = cwgr_pkg::QNAN32;
      else sval = {sp, cwgr_pkg::INF32[30:0]};
    end else if (cinf) begin
      sval = c_i;
    end else if (azero || bzero) begin
      sval = czero ? {sp & sc, 31'b0} : c_i;
    end else begin
      spec = 1'b0;
    end
  end

  logic        s1_spec_q, s1_czero_q, s1_sp_q, s1_sc_q;
  logic [31:0] s1_sval_q;
  logic [47:0] s1_mp_q;
  logic [23:0] s1_mc_q;
  logic signed [11:0] s1_ep_q, s1_ec_q;

  always_ff @(posedge clk_i) begin
    s1_spec_q  <= spec;
    s1_sval_q  <= sval;
    s1_czero_q <= czero;
    s1_sp_q    <= sp;
    s1_sc_q    <= sc;
    s1_mp_q    <= ma * mb;
    s1_ep_q    <= ea + eb;
    s1_mc_q    <= mc;
    s1_ec_q    <= ec;
  end

  // stage 2: normalize both addends to bit 61, order by exponent
  logic [5:0]  tp, tc;
  logic [11:0] dp, dc;
  logic [63:0] mpn, mcn, hi, lo;
  logic signed [11:0] epn, ecn, eh;
  logic        shi, slo;
  logic [11:0] dd;

  always_comb begin
    tp  = cwgr_pkg::top_bit64({16'b0, s1_mp_q});
    tc  = cwgr_pkg::top_bit64({40'b0, s1_mc_q});
    dp  = 12'd61 - {6'b0, tp};
    dc  = 12'd61 - {6'b0, tc};
    mpn = {16'b0, s1_mp_q} << dp[5:0];
    mcn = {40'b0, s1_mc_q} << dc[5:0];
    epn = s1_ep_q - $signed(dp);
    ecn = s1_ec_q - $signed(dc);
    priority if (s1_czero_q) begin
      hi = mpn; shi = s1_sp_q; lo = '0; slo = s1_sp_q; eh = epn; dd = '0;
    end else if (epn >= ecn) begin
      hi = mpn; shi = s1_sp_q; lo = mcn; slo = s1_sc_q; eh = epn;
      dd = 12'(epn - ecn);
    end else begin
      hi = mcn; shi = s1_sc_q; lo = mpn; slo = s1_sp_q; eh = ecn;
      dd = 12'(ecn - epn);
    end
  end

  logic        s2_spec_q, s2_shi_q, s2_slo_q;
  logic [31:0] s2_sval_q;
  logic [63:0] s2_hi_q, s2_lo_q;
  logic [11:0] s2_d_q;
  logic signed [11:0] s2_e_q;

  always_ff @(posedge clk_i) begin
    s2_spec_q <= s1_spec_q;
    s2_sval_q <= s1_sval_q;
    s2_shi_q  <= shi;
    s2_slo_q  <= slo;
    s2_hi_q   <= hi;
    s2_lo_q   <= lo;
    s2_d_q    <= dd;
    s2_e_q    <= eh;
  end

  // stage 3: align the smaller addend with sticky, add or subtract
  logic [63:0] lal, sum;
  logic        rs, stk;

  always_comb begin
    stk = |(s2_lo_q & ((64'd1 << s2_d_q[5:0]) - 64'd1));
    if (s2_d_q >= 12'd63) lal = 64'd1;
    else lal = (s2_lo_q >> s2_d_q[5:0]) | {63'b0, stk};
    priority if (s2_shi_q == s2_slo_q) begin
      sum = s2_hi_q + lal; rs = s2_shi_q;
    end else if (s2_hi_q >= lal) begin
      sum = s2_hi_q - lal; rs = s2_shi_q;
    end else begin
      sum = lal - s2_hi_q; rs = s2_slo_q;
    end
  end

  logic        s3_spec_q, s3_rs_q;
  logic [31:0] s3_sval_q;
  logic [63:0] s3_sum_q;
  logic signed [11:0] s3_e_q;

  always_ff @(posedge clk_i) begin
    s3_spec_q <= s2_spec_q;
    s3_sval_q <= s2_sval_q;
    s3_rs_q   <= rs;
    s3_sum_q  <= sum;
    s3_e_q    <= s2_e_q;
  end

  // stage 4: leading one and rounding position with subnormal floor
  logic [5:0] lead;
  logic signed [11:0] sh, lim;

  always_comb begin
    lead = cwgr_pkg::top_bit64(s3_sum_q);
    sh   = $signed({6'b0, lead}) - 12'sd23;
    lim  = -12'sd149 - s3_e_q;
    if (lim > sh) sh = lim;
  end

  logic        s4_spec_q, s4_rs_q, s4_zero_q;
  logic [31:0] s4_sval_q;
  logic [63:0] s4_m_q;
  logic signed [11:0] s4_e_q, s4_sh_q;

  always_ff @(posedge clk_i) begin
    s4_spec_q <= s3_spec_q;
    s4_sval_q <= s3_sval_q;
    s4_rs_q   <= s3_rs_q;
    s4_zero_q <= s3_sum_q == '0;
    s4_m_q    <= s3_sum_q;
    s4_e_q    <= s3_e_q;
    s4_sh_q   <= sh;
  end

  // stage 5: shift, round to nearest even, pack
  logic [63:0] q, rem, half;
  logic [11:0] nsh;
  logic signed [11:0] qe, biased;
  logic [31:0] packed_res;

  always_comb begin
    nsh  = 12'(-s4_sh_q);
    rem  = s4_m_q & ((64'd1 << s4_sh_q[5:0]) - 64'd1);
    half = 64'd1 << 6'(s4_sh_q[5:0] - 6'd1);
    priority if (s4_sh_q <= 12'sd0) begin
      q = s4_m_q << nsh[5:0];
    end else if (s4_sh_q >= 12'sd64) begin
      q = '0;
    end else begin
      q = s4_m_q >> s4_sh_q[5:0];
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    qe = s4_e_q + s4_sh_q;
    if (q[24]) begin
      q  = q >> 1;
      qe = qe + 12'sd1;
    end
    biased = qe + 12'sd150;
    priority if (q == '0) begin
      packed_res = {s4_rs_q, 31'b0};
    end else if (q[23]) begin
      if (biased >= 12'sd255) packed_res = {s4_rs_q, cwgr_pkg::INF32[30:0]};
      else packed_res = {s4_rs_q, biased[7:0], q[22:0]};
    end else begin
      packed_res = {s4_rs_q, 8'b0, q[22:0]};
    end
  end

  // result select
  always_comb begin
    priority if (s4_spec_q) res_o = s4_sval_q;
    else if (s4_zero_q) res_o = '0;
    else res_o = packed_res;
  end

endmodule

// File: rtl/cwgr_lane.sv
// ----------------------------------------------------------------------------
// cwgr_lane
// One lane: fp32 partial sum and running total around its own fma unit,
// shared by the mac and flush passes, bf16 view of the running total.
// ----------------------------------------------------------------------------
module cwgr_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          act_i,
  input  logic [15:0]          res_i,
  input  cwgr_pkg::lane_ctrl_t ctrl_i,
  output logic [15:0]          grad_o
);

  logic [31:0] op_a_q, op_b_q, op_c_q;
  logic [31:0] partial_q, total_q;
  logic [31:0] fma_res;

  cwgr_fma u_fma (
    .clk_i (clk_i),
    .a_i   (op_a_q),
    .b_i   (op_b_q),
    .c_i   (op_c_q),
    .res_o (fma_res)
  );

  // operand registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_mac) begin
      op_a_q <= act_i;
      op_b_q <= {res_i, 16'h0000};
      op_c_q <= partial_q;
    end else if (ctrl_i.load_flush) begin
      op_a_q <= fma_res;
      op_b_q <= cwgr_pkg::ONE32;
      op_c_q <= total_q;
    end
  end

  // partial and total state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      total_q   <= '0;
    end else begin
      if (ctrl_i.clear) begin
        partial_q <= '0;
        total_q   <= '0;
      end else begin
        if (ctrl_i.wr_partial) partial_q <= fma_res;
        else if (ctrl_i.load_flush) partial_q <= '0;
        if (ctrl_i.wr_total) total_q <= fma_res;
      end
    end
  end

  assign grad_o = cwgr_pkg::to_bf16(total_q);

endmodule

// File: rtl/chunked_weight_gradient_reducer.sv
// ----------------------------------------------------------------------------
// chunked_weight_gradient_reducer
// Eight-lane fp32 weight gradient reducer with chunked accumulation and
// bf16 results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample per request:
//   an fp32 activation, eight bf16 residuals and last_sample. Output channel
//   (out_valid_o / out_stall_i) carries eight bf16 gradients, one request per
//   sample marked last.
//   Each lane runs a 4-stage fp32 fma pipeline; a sample goes through it once
//   for the multiply-add into the partial, and once more when the chunk is
//   flushed into the running total. The partial-sum loop through this
//   pipeline sets the rate: a new sample is taken only after the previous
//   one has left its mac pass, its flush pass if it closes a chunk, and the
//   emit state if it is marked last, where its result is registered.
//   A stalled result stays in the output register while the next sample is
//   taken; a further last sample waits in its emit state until the output
//   register frees.
//   Reset clears partials, totals, the chunk count and the output valid.
// ----------------------------------------------------------------------------
module chunked_weight_gradient_reducer #(
  parameter int unsigned CHUNK = cwgr_pkg::CHUNK_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] activation_i,
  input  logic [15:0] residual_0_i,
  input  logic [15:0] residual_1_i,
  input  logic [15:0] residual_2_i,
  input  logic [15:0] residual_3_i,
  input  logic [15:0] residual_4_i,
  input  logic [15:0] residual_5_i,
  input  logic [15:0] residual_6_i,
  input  logic [15:0] residual_7_i,
  input  logic        last_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] gradient_0_o,
  output logic [15:0] gradient_1_o,
  output logic [15:0] gradient_2_o,
  output logic [15:0] gradient_3_o,
  output logic [15:0] gradient_4_o,
  output logic [15:0] gradient_5_o,
  output logic [15:0] gradient_6_o,
  output logic [15:0] gradient_7_o
);

  localparam int unsigned CW = (CHUNK > 1) ? $clog2(CHUNK) : 1;
  localparam int unsigned LW = $clog2(cwgr_pkg::FMA_LAT + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [LW-1:0] cnt_q;
  logic [CW-1:0] chunk_q;
  logic        last_q, flush_q;
  logic        out_valid_q;
  logic [15:0] grad_q [cwgr_pkg::LANES];
  logic [15:0] lane_grad [cwgr_pkg::LANES];
  logic [15:0] residual [cwgr_pkg::LANES];
  logic        accept, done, out_free, flush;
  cwgr_pkg::lane_ctrl_t ctrl;

  assign residual[0] = residual_0_i;
  assign residual[1] = residual_1_i;
  assign residual[2] = residual_2_i;
  assign residual[3] = residual_3_i;
  assign residual[4] = residual_4_i;
  assign residual[5] = residual_5_i;
  assign residual[6] = residual_6_i;
  assign residual[7] = residual_7_i;

  // handshake and sequencing conditions
  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign done       = cnt_q == LW'(cwgr_pkg::FMA_LAT);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign flush      = last_sample_i || (chunk_q >= CW'(CHUNK - 1));

  // lane control
  always_comb begin
    ctrl.load_mac   = accept;
    ctrl.wr_partial = (state_q == ST_MAC) && done && !flush_q;
    ctrl.load_flush = (state_q == ST_MAC) && done && flush_q;
    ctrl.wr_total   = (state_q == ST_FLUSH) && done;
    ctrl.clear      = (state_q == ST_EMIT) && out_free;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MAC;
      ST_MAC:   if (done) state_d = flush_q ? ST_FLUSH : ST_IDLE;
      ST_FLUSH: if (done) state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      chunk_q <= '0;
      last_q  <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept || ctrl.load_flush) cnt_q <= '0;
      else if (!done) cnt_q <= cnt_q + LW'(1);
      if (accept) begin
        last_q  <= last_sample_i;
        flush_q <= flush;
        chunk_q <= flush ? '0 : chunk_q + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) grad_q <= lane_grad;
  end

  // lanes
  for (genvar k = 0; k < cwgr_pkg::LANES; k++) begin : g_lane
    cwgr_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .act_i  (activation_i),
      .res_i  (residual[k]),
      .ctrl_i (ctrl),
      .grad_o (lane_grad[k])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign gradient_0_o = grad_q[0];
  assign gradient_1_o = grad_q[1];
  assign gradient_2_o = grad_q[2];
  assign gradient_3_o = grad_q[3];
  assign gradient_4_o = grad_q[4];
  assign gradient_5_o = grad_q[5];
  assign gradient_6_o = grad_q[6];
  assign gradient_7_o = grad_q[7];

  // checks
  a_accept_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MAC)
    else $error("accepted request did not start the mac pass");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_EMIT)
    else $error("result raised outside emit");

  a_chunk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_q <= CW'(CHUNK - 1))
    else $error("chunk count out of range");

  a_flush_needs_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> flush_q)
    else $error("flush pass without a flush request");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chunked weight gradient reducer: drives fp32
// activations and bf16 residuals with random gaps, predicts every bf16
// gradient with a bit-exact fp32 fused multiply-add model, and compares.
// ----------------------------------------------------------------------------
module testbench;

  // gradient scoreboard: predicts lane sums, holds expected gradient requests
  class gradient_board;
    bit [31:0]  partial[cwgr_pkg::LANES];
    bit [31:0]  total[cwgr_pkg::LANES];
    int         count;
    bit [127:0] pending_q[$];
    int         errors;

    function void clear_lanes();
      for (int k = 0; k < cwgr_pkg::LANES; k++) begin
        partial[k] = '0;
        total[k] = '0;
      end
      count = 0;
    endfunction

    function int msb(bit [63:0] v);
      int n;
      n = -1;
      for (int i = 0; i < 64; i++) if (v[i]) n = i;
      return n;
    endfunction

    // round sign * m * 2^e to fp32, nearest even, m nonzero
    function bit [31:0] round32(bit sign, bit [63:0] m, int e);
      int sh, qe;
      bit [63:0] q, rem, half;
      sh = msb(m) - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh <= 0) begin
        q = m << (-sh);
      end else if (sh >= 64) begin
        q = '0;
      end else begin
        rem = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        q = m >> sh;
        if (rem > half || (rem == half && q[0])) q++;
      end
      qe = e + sh;
      if (q == 0) return {sign, 31'b0};
      if (q >= (64'd1 << 24)) begin
        q >>= 1;
        qe++;
      end
      if (q >= (64'd1 << 23)) begin
        if (qe + 150 >= 255) return {sign, 31'h7F80_0000};
        return {sign, 8'(qe + 150), q[22:0]};
      end
      return {sign, 8'b0, q[22:0]};
    endfunction

    function void split32(bit [31:0] x, output bit [63:0] m, output int e);
      if (x[30:23] == 0) begin
        m = {41'b0, x[22:0]};
        e = -149;
      end else begin
        m = {40'b0, 1'b1, x[22:0]};
        e = int'(x[30:23]) - 150;
      end
    endfunction

    // a * b + c with one rounding
    function bit [31:0] fma32(bit [31:0] a, bit [31:0] b, bit [31:0] c);
      bit sp, shi, slo, rs, ainf, binf, cinf, azero, bzero, czero, sticky;
      bit [63:0] ma, mb, mc, mp, hi, lo, sum;
      int ea, eb, ec, ep, d;
      sp = a[31] ^ b[31];
      ainf = a[30:23] == 8'hFF;
      binf = b[30:23] == 8'hFF;
      cinf = c[30:23] == 8'hFF;
      azero = a[30:0] == 0;
      bzero = b[30:0] == 0;
      czero = c[30:0] == 0;
      if ((ainf && a[22:0] != 0) || (binf && b[22:0] != 0) || (cinf && c[22:0] != 0))
        return cwgr_pkg::QNAN32;
      if (ainf || binf) begin
        if (azero || bzero) return cwgr_pkg::QNAN32;
        if (cinf && c[31] != sp) return cwgr_pkg::QNAN32;
        return {sp, 31'h7F80_0000};
      end
      if (cinf) return c;
      split32(a, ma, ea);
      split32(b, mb, eb);
      split32(c, mc, ec);
      mp = ma * mb;
      ep = ea + eb;
      if (mp == 0) begin
        if (czero) return {sp & c[31], 31'b0};
        return c;
      end
      if (czero) return round32(sp, mp, ep);
      d = 61 - msb(mp);
      mp <<= d;
      ep -= d;
      d = 61 - msb(mc);
      mc <<= d;
      ec -= d;
      if (ep >= ec) begin
        hi = mp; shi = sp; lo = mc; slo = c[31]; d = ep - ec;
      end else begin
        hi = mc; shi = c[31]; lo = mp; slo = sp; d = ec - ep;
        ep = ec;
      end
      if (d >= 63) begin
        lo = 64'd1;
      end else if (d > 0) begin
        sticky = (lo & ((64'd1 << d) - 64'd1)) != 0;
        lo = (lo >> d) | {63'b0, sticky};
      end
      if (shi == slo) begin
        sum = hi + lo; rs = shi;
      end else if (hi >= lo) begin
        sum = hi - lo; rs = shi;
      end else begin
        sum = lo - hi; rs = slo;
      end
      if (sum == 0) return '0;
      return round32(rs, sum, ep);
    endfunction

    function bit [15:0] bf16_of(bit [31:0] x);
      bit [31:0] s;
      s = x + 32'h0000_7FFF + {31'b0, x[16]};
      return s[31:16];
    endfunction

    // accepted sample request
    function void note_sample(bit [31:0] act, bit [127:0] res, bit last);
      bit [127:0] grads;
      for (int k = 0; k < cwgr_pkg::LANES; k++)
        partial[k] = fma32(act, {res[16*k +: 16], 16'b0}, partial[k]);
      if (last || count >= cwgr_pkg::CHUNK_DEF - 1) begin
        for (int k = 0; k < cwgr_pkg::LANES; k++) begin
          total[k] = fma32(partial[k], cwgr_pkg::ONE32, total[k]);
          partial[k] = '0;
        end
        count = 0;
      end else begin
        count++;
      end
      if (last) begin
        for (int k = 0; k < cwgr_pkg::LANES; k++) grads[16*k +: 16] = bf16_of(total[k]);
        pending_q = {pending_q, grads};
        clear_lanes();
      end
    endfunction

    // accepted gradient request
    function void check_result(bit [127:0] got);
      bit [127:0] want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected gradient request %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      for (int k = 0; k < cwgr_pkg::LANES; k++)
        if (want[16*k +: 16] != got[16*k +: 16]) begin
          $display("%0t: gradient_%0d expected %h actual %h", $time, k,
                   want[16*k +: 16], got[16*k +: 16]);
          errors++;
        end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] activation_i = '0;
  logic [15:0] residual_i [cwgr_pkg::LANES];
  logic        last_sample_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [15:0] gradient_o [cwgr_pkg::LANES];

  gradient_board board;

  initial for (int k = 0; k < cwgr_pkg::LANES; k++) residual_i[k] = '0;

  chunked_weight_gradient_reducer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .activation_i,
    .residual_0_i(residual_i[0]), .residual_1_i(residual_i[1]),
    .residual_2_i(residual_i[2]), .residual_3_i(residual_i[3]),
    .residual_4_i(residual_i[4]), .residual_5_i(residual_i[5]),
    .residual_6_i(residual_i[6]), .residual_7_i(residual_i[7]),
    .last_sample_i, .out_valid_o, .out_stall_i,
    .gradient_0_o(gradient_o[0]), .gradient_1_o(gradient_o[1]),
    .gradient_2_o(gradient_o[2]), .gradient_3_o(gradient_o[3]),
    .gradient_4_o(gradient_o[4]), .gradient_5_o(gradient_o[5]),
    .gradient_6_o(gradient_o[6]), .gradient_7_o(gradient_o[7])
  );

  // clock and reset
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // watch both channels
  always @(posedge clk_i) begin
    bit [127:0] v;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      for (int k = 0; k < cwgr_pkg::LANES; k++) v[16*k +: 16] = residual_i[k];
      board.note_sample(activation_i, v, last_sample_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      for (int k = 0; k < cwgr_pkg::LANES; k++) v[16*k +: 16] = gradient_o[k];
      board.check_result(v);
    end
  end

  function automatic bit [31:0] pick_fp32();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
    if (r < 85) return $urandom;
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {1'($urandom), 8'h00, 23'($urandom)};
      3: return {1'($urandom), 31'h7F80_0000};
      4: return {1'($urandom), 8'hFE, 23'($urandom)};
      5: return 32'h7FC0_0000;
      6: return {1'($urandom), 8'h01, 23'($urandom)};
      default: return {1'($urandom), 8'h7F, 23'h0};
    endcase
  endfunction

  function automatic bit [15:0] pick_bf16();
    bit [31:0] w;
    w = pick_fp32();
    return w[31:16];
  endfunction

  // one sample request, then a random gap that may be zero
  task automatic send_sample(bit [31:0] act, bit [127:0] res, bit last);
    int r, gap;
    in_valid_i <= 1'b1;
    activation_i <= act;
    for (int k = 0; k < cwgr_pkg::LANES; k++) residual_i[k] <= res[16*k +: 16];
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_uniform(bit [31:0] act, bit [15:0] res, bit last);
    send_sample(act, {cwgr_pkg::LANES{res}}, last);
  endtask

  task automatic send_random(bit last);
    bit [127:0] res;
    for (int k = 0; k < cwgr_pkg::LANES; k++) res[16*k +: 16] = pick_bf16();
    send_sample(pick_fp32(), res, last);
  endtask

  // receiver: one long hold-off first, then random stalls
  initial begin
    int r, n;
    @(posedge rst_ni);
    repeat (400) @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        out_stall_i <= 1'b0;
        n = $urandom_range(1, 20);
      end else if (r < 9) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        n = $urandom_range(20, 60);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // stimulus
  initial begin
    int sent, len;
    board = new();
    board.clear_lanes();
    board.errors = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    // extremes and zeros
    send_uniform(32'h0000_0000, 16'h0000, 1'b1);
    send_uniform(32'h8000_0000, 16'h8000, 1'b0);
    send_uniform(32'h0000_0000, 16'h8000, 1'b1);
    send_uniform(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_uniform(32'h3F80_0000, 16'h3F80, 1'b0);
    send_uniform(32'hBF80_0000, 16'h3F80, 1'b1);
    // subnormal operands
    send_uniform(32'h0000_0001, 16'h3F80, 1'b0);
    send_uniform(32'h007F_FFFF, 16'h0001, 1'b1);
    // overflow to infinity, then a negative product of that size onto an infinite partial
    send_uniform(32'h7F7F_FFFF, 16'h7F7F, 1'b1);
    send_uniform(32'h7F7F_FFFF, 16'h7F7F, 1'b0);
    send_uniform(32'h7F7F_FFFF, 16'hFF7F, 1'b1);
    // infinity times zero, nan operand
    send_uniform(32'h7F80_0000, 16'h0000, 1'b1);
    send_uniform(32'h7FC0_0000, 16'h3F80, 1'b1);
    send_uniform(32'h3F80_0000, 16'h7FC1, 1'b1);
    send_uniform(32'hFF80_0000, 16'h3F80, 1'b1);
    // bf16 rounding ties and a value just above a tie
    send_uniform(32'h3F80_8000, 16'h3F80, 1'b1);
    send_uniform(32'h3F81_8000, 16'h3F80, 1'b1);
    send_uniform(32'h3F80_8001, 16'h3F80, 1'b1);
    // mixed lanes, the sender keeps offering during the hold-off
    repeat (6) send_random(1'b0);
    send_random(1'b1);
    sent = 25;
    // random groups, a few long enough to flush a chunk without last
    while (sent < 1000) begin
      len = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 12) : $urandom_range(120, 270);
      for (int i = 0; i < len; i++) send_random(i == len - 1);
      sent += len;
    end
    in_valid_i <= 1'b0;
    // let the monitor note the final request before draining
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: chunked_weight_gradient_reducer.f
rtl/cwgr_pkg.sv
rtl/cwgr_fma.sv
rtl/cwgr_lane.sv
rtl/chunked_weight_gradient_reducer.sv
dv/testbench.sv
